FILE: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define PC_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define PC_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

FILE: rtl/pc_pkg.sv
`default_nettype none

package pc_pkg;

	localparam int unsigned MAX_PAIRS = 4096;
	localparam int unsigned SMP_W     = 16;
	localparam int unsigned CNT_W     = $clog2(MAX_PAIRS + 1);
	localparam int unsigned SUM_W     = SMP_W + CNT_W;
	localparam int unsigned SQ_W      = 2 * SMP_W + CNT_W;
	// n * sum of squares and the variance terms fit here, sign included
	localparam int unsigned OP_W      = 2 * CNT_W + 2 * SMP_W - 1;
	localparam int unsigned PROD_W    = 2 * OP_W;
	localparam int unsigned Q_W       = 2 * SMP_W - 1;
	localparam int unsigned ROOT_W    = SMP_W;
	localparam int unsigned CYC_W     = $clog2(OP_W);

	typedef struct packed {
		logic signed [SMP_W-1:0] x_sample;
		logic signed [SMP_W-1:0] y_sample;
		logic                    last_pair;
	} pc_sample_t;

	typedef struct packed {
		logic signed [SMP_W-1:0] correlation;
		logic                    degenerate;
		logic                    too_many;
	} pc_result_t;

	typedef enum logic [2:0] {
		MUL_NSXX,
		MUL_SXSX,
		MUL_NSYY,
		MUL_SYSY,
		MUL_NSXY,
		MUL_SXSY,
		MUL_DXDY,
		MUL_NUMSQ
	} pc_mul_op_t;

	typedef struct packed {
		logic       take;
		logic       mul_load;
		logic       mul_step;
		logic       mul_cap;
		pc_mul_op_t mul_op;
		logic       div_load;
		logic       div_step;
		logic       sqrt_load;
		logic       sqrt_step;
		logic       out_load;
	} pc_cmd_t;

	typedef struct packed {
		logic last_pending;
		logic degenerate;
	} pc_stat_t;

endpackage

`default_nettype wire

FILE: rtl/pearson_correlation.sv
// Channel   Direction  Handshake                    Payload
// sample    in         sample_valid / sample_ready  pc_sample_t (x, y, last_pair)
// result    out        result_valid / result_ready  pc_result_t (r, degenerate, too_many)
//
// Pairs are taken one per cycle while accumulating with no last pair pending;
// the pair marked last passes the input stage register before it joins the sums.
// A result then takes eight passes of the serial multiplier, 31 divide steps and
// 16 square-root steps; a degenerate set skips the divide and root.
// No pair is taken from a last pair until its result sits in the output register;
// a stalled result holds the block only when the next result is ready to go out.
// Reset clears the sums, the count, the overflow flag and result_valid.
`default_nettype none

module pearson_correlation (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sample_valid,
	output logic               sample_ready,
	input  pc_pkg::pc_sample_t sample,
	output logic               result_valid,
	input  logic               result_ready,
	output pc_pkg::pc_result_t result
);

	pc_pkg::pc_cmd_t  cmd;
	pc_pkg::pc_stat_t stat;

	pc_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.stat         (stat),
		.cmd          (cmd)
	);

	pc_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sample (sample),
		.stat   (stat),
		.result (result)
	);

endmodule

`default_nettype wire

FILE: rtl/pc_mul.sv
`default_nettype none

module pc_mul (
	input  logic                              clk,
	input  logic                              load,
	input  logic                              step,
	input  logic signed [pc_pkg::OP_W-1:0]    a,
	input  logic signed [pc_pkg::OP_W-1:0]    b,
	output logic        [pc_pkg::PROD_W-1:0]  mag,
	output logic                              neg
);

	logic [pc_pkg::OP_W-1:0]   a_abs;
	logic [pc_pkg::OP_W-1:0]   b_abs;
	logic [pc_pkg::OP_W-1:0]   a_q;
	logic [pc_pkg::PROD_W-1:0] p_q;
	logic                      neg_q;
	logic [pc_pkg::OP_W:0]     sum;

	assign a_abs = a[pc_pkg::OP_W-1] ? $unsigned(-a) : $unsigned(a);
	assign b_abs = b[pc_pkg::OP_W-1] ? $unsigned(-b) : $unsigned(b);

	// shift-add on magnitudes: multiplier bits leave the low half LSB first
	assign sum = {1'b0, p_q[pc_pkg::PROD_W-1:pc_pkg::OP_W]}
		+ (p_q[0] ? {1'b0, a_q} : {(pc_pkg::OP_W + 1){1'b0}});

	always_ff @(posedge clk) begin
		if (load) begin
			a_q   <= a_abs;
			p_q   <= {{pc_pkg::OP_W{1'b0}}, b_abs};
			neg_q <= a[pc_pkg::OP_W-1] ^ b[pc_pkg::OP_W-1];
		end else if (step) begin
			p_q <= {sum, p_q[pc_pkg::OP_W-1:1]};
		end
	end

	assign mag = p_q;
	assign neg = neg_q;

endmodule

`default_nettype wire

FILE: rtl/pc_dp.sv
`default_nettype none
`include "assert_macros.svh"

module pc_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  pc_pkg::pc_cmd_t    cmd,
	input  pc_pkg::pc_sample_t sample,
	output pc_pkg::pc_stat_t   stat,
	output pc_pkg::pc_result_t result
);

	localparam int unsigned SMP_W  = pc_pkg::SMP_W;
	localparam int unsigned CNT_W  = pc_pkg::CNT_W;
	localparam int unsigned SUM_W  = pc_pkg::SUM_W;
	localparam int unsigned SQ_W   = pc_pkg::SQ_W;
	localparam int unsigned OP_W   = pc_pkg::OP_W;
	localparam int unsigned PROD_W = pc_pkg::PROD_W;
	localparam int unsigned Q_W    = pc_pkg::Q_W;
	localparam int unsigned ROOT_W = pc_pkg::ROOT_W;

	// input stage
	logic                      valid_s1;
	logic                      last_s1;
	logic signed [SMP_W-1:0]   x_s1;
	logic signed [SMP_W-1:0]   y_s1;
	logic signed [2*SMP_W-1:0] xx_s1;
	logic signed [2*SMP_W-1:0] yy_s1;
	logic signed [2*SMP_W-1:0] xy_s1;

	// running sums
	logic        [CNT_W-1:0]   count_q;
	logic signed [SUM_W-1:0]   sum_x_q;
	logic signed [SUM_W-1:0]   sum_y_q;
	logic signed [SQ_W-1:0]    sum_xx_q;
	logic signed [SQ_W-1:0]    sum_yy_q;
	logic signed [SQ_W-1:0]    sum_xy_q;
	logic                      ovf_q;

	// final terms
	logic signed [OP_W-1:0]    n_op;
	logic signed [OP_W-1:0]    mul_a;
	logic signed [OP_W-1:0]    mul_b;
	logic        [PROD_W-1:0]  mul_mag;
	logic                      mul_neg;
	logic signed [OP_W-1:0]    mag_lo;
	logic signed [OP_W-1:0]    prod_lo;
	logic signed [OP_W-1:0]    diff_lo;
	logic signed [OP_W-1:0]    tmp_q;
	logic signed [OP_W-1:0]    dx_q;
	logic signed [OP_W-1:0]    dy_q;
	logic signed [OP_W-1:0]    num_q;
	logic        [PROD_W-1:0]  dxdy_q;
	logic        [PROD_W-1:0]  nsq_q;

	// divider
	logic [PROD_W-1:0]         rem_q;
	logic [Q_W-1:0]            quo_q;
	logic [PROD_W:0]           div_diff;
	logic                      div_ge;
	logic [PROD_W-1:0]         div_next;

	// square root
	logic [2*ROOT_W-1:0]       sq_q;
	logic [ROOT_W:0]           srem_q;
	logic [ROOT_W-1:0]         root_q;
	logic [ROOT_W+2:0]         sq_cur;
	logic [ROOT_W+2:0]         sq_trial;
	logic [ROOT_W+3:0]         sq_diff;
	logic                      sq_ge;

	logic [ROOT_W-1:0]         corr;
	pc_pkg::pc_result_t        result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
		end else begin
			valid_s1 <= cmd.take;
			last_s1  <= cmd.take && sample.last_pair;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			x_s1  <= sample.x_sample;
			y_s1  <= sample.y_sample;
			xx_s1 <= sample.x_sample * sample.x_sample;
			yy_s1 <= sample.y_sample * sample.y_sample;
			xy_s1 <= sample.x_sample * sample.y_sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			sum_x_q  <= '0;
			sum_y_q  <= '0;
			sum_xx_q <= '0;
			sum_yy_q <= '0;
			sum_xy_q <= '0;
			ovf_q    <= 1'b0;
		end else if (cmd.out_load) begin
			count_q  <= '0;
			sum_x_q  <= '0;
			sum_y_q  <= '0;
			sum_xx_q <= '0;
			sum_yy_q <= '0;
			sum_xy_q <= '0;
			ovf_q    <= 1'b0;
		end else if (valid_s1) begin
			// drop the pair once the set is full
			if (count_q < CNT_W'(pc_pkg::MAX_PAIRS)) begin
				count_q  <= count_q + CNT_W'(1);
				sum_x_q  <= sum_x_q + SUM_W'(x_s1);
				sum_y_q  <= sum_y_q + SUM_W'(y_s1);
				sum_xx_q <= sum_xx_q + SQ_W'(xx_s1);
				sum_yy_q <= sum_yy_q + SQ_W'(yy_s1);
				sum_xy_q <= sum_xy_q + SQ_W'(xy_s1);
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end

	assign n_op = OP_W'({1'b0, count_q});

	always_comb begin
		case (cmd.mul_op)
			pc_pkg::MUL_NSXX: begin
				mul_a = n_op;
				mul_b = OP_W'(sum_xx_q);
			end
			pc_pkg::MUL_SXSX: begin
				mul_a = OP_W'(sum_x_q);
				mul_b = OP_W'(sum_x_q);
			end
			pc_pkg::MUL_NSYY: begin
				mul_a = n_op;
				mul_b = OP_W'(sum_yy_q);
			end
			pc_pkg::MUL_SYSY: begin
				mul_a = OP_W'(sum_y_q);
				mul_b = OP_W'(sum_y_q);
			end
			pc_pkg::MUL_NSXY: begin
				mul_a = n_op;
				mul_b = OP_W'(sum_xy_q);
			end
			pc_pkg::MUL_SXSY: begin
				mul_a = OP_W'(sum_x_q);
				mul_b = OP_W'(sum_y_q);
			end
			pc_pkg::MUL_DXDY: begin
				mul_a = dx_q;
				mul_b = dy_q;
			end
			pc_pkg::MUL_NUMSQ: begin
				mul_a = num_q;
				mul_b = num_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	pc_mul u_mul (
		.clk  (clk),
		.load (cmd.mul_load),
		.step (cmd.mul_step),
		.a    (mul_a),
		.b    (mul_b),
		.mag  (mul_mag),
		.neg  (mul_neg)
	);

	assign mag_lo  = mul_mag[OP_W-1:0];
	assign prod_lo = mul_neg ? -mag_lo : mag_lo;
	assign diff_lo = mul_neg ? tmp_q + mag_lo : tmp_q - mag_lo;

	always_ff @(posedge clk) begin
		if (cmd.mul_cap) begin
			case (cmd.mul_op)
				pc_pkg::MUL_NSXX,
				pc_pkg::MUL_NSYY,
				pc_pkg::MUL_NSXY:  tmp_q  <= prod_lo;
				pc_pkg::MUL_SXSX:  dx_q   <= diff_lo;
				pc_pkg::MUL_SYSY:  dy_q   <= diff_lo;
				pc_pkg::MUL_SXSY:  num_q  <= diff_lo;
				pc_pkg::MUL_DXDY:  dxdy_q <= mul_mag;
				pc_pkg::MUL_NUMSQ: nsq_q  <= mul_mag;
				default: ;
			endcase
		end
	end

	// fractional divide: num^2 <= dx*dy, so the remainder left by each compare stays below the divisor
	assign div_diff = {1'b0, rem_q} - {1'b0, dxdy_q};
	assign div_ge   = !div_diff[PROD_W];
	assign div_next = div_ge ? div_diff[PROD_W-1:0] : rem_q;

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			rem_q <= nsq_q;
			quo_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= {div_next[PROD_W-2:0], 1'b0};
			quo_q <= {quo_q[Q_W-2:0], div_ge};
		end
	end

	// restoring square root, two radicand bits per step
	assign sq_cur   = {srem_q, sq_q[2*ROOT_W-1 -: 2]};
	assign sq_trial = {1'b0, root_q, 2'b01};
	assign sq_diff  = {1'b0, sq_cur} - {1'b0, sq_trial};
	assign sq_ge    = !sq_diff[ROOT_W+3];

	always_ff @(posedge clk) begin
		if (cmd.sqrt_load) begin
			sq_q   <= (2*ROOT_W)'(quo_q);
			srem_q <= '0;
			root_q <= '0;
		end else if (cmd.sqrt_step) begin
			srem_q <= sq_ge ? sq_diff[ROOT_W:0] : sq_cur[ROOT_W:0];
			root_q <= {root_q[ROOT_W-2:0], sq_ge};
			sq_q   <= {sq_q[2*ROOT_W-3:0], 2'b00};
		end
	end

	always_comb begin
		if (stat.degenerate) begin
			corr = '0;
		end else if (num_q[OP_W-1]) begin
			corr = (~root_q) + ROOT_W'(1);
		end else if (root_q[ROOT_W-1]) begin
			// saturate +1
			corr = {1'b0, {(ROOT_W-1){1'b1}}};
		end else begin
			corr = root_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			result_q.correlation <= corr;
			result_q.degenerate  <= stat.degenerate;
			result_q.too_many    <= ovf_q;
		end
	end

	assign stat.last_pending = valid_s1 && last_s1;
	assign stat.degenerate   = (count_q < CNT_W'(2)) || (dx_q == '0) || (dy_q == '0);
	assign result            = result_q;

	`PC_ASSERT_NXT(a_last_blocks_take, cmd.take && sample.last_pair, !cmd.take)
	`PC_ASSERT_IMP(a_count_cap, 1'b1, count_q <= CNT_W'(pc_pkg::MAX_PAIRS))
	`PC_ASSERT_NXT(a_degen_zero, cmd.out_load && stat.degenerate, result_q.correlation == '0)

endmodule

`default_nettype wire

FILE: rtl/pc_ctrl.sv
`default_nettype none
`include "assert_macros.svh"

module pc_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             sample_valid,
	output logic             sample_ready,
	output logic             result_valid,
	input  logic             result_ready,
	input  pc_pkg::pc_stat_t stat,
	output pc_pkg::pc_cmd_t  cmd
);

	localparam int unsigned CYC_W = pc_pkg::CYC_W;

	typedef enum logic [3:0] {
		ST_ACC,
		ST_MLOAD,
		ST_MRUN,
		ST_MDONE,
		ST_CHECK,
		ST_DRUN,
		ST_SLOAD,
		ST_SRUN,
		ST_RESULT
	} state_t;

	state_t             state_q;
	pc_pkg::pc_mul_op_t op_q;
	logic [CYC_W-1:0]   cnt_q;
	logic               result_valid_q;
	logic               result_free;

	assign result_free  = !result_valid_q || result_ready;
	assign sample_ready = (state_q == ST_ACC) && !stat.last_pending;
	assign result_valid = result_valid_q;

	always_comb begin
		cmd        = '0;
		cmd.take   = sample_valid && sample_ready;
		cmd.mul_op = op_q;
		case (state_q)
			ST_MLOAD:  cmd.mul_load  = 1'b1;
			ST_MRUN:   cmd.mul_step  = 1'b1;
			ST_MDONE:  cmd.mul_cap   = 1'b1;
			ST_CHECK:  cmd.div_load  = 1'b1;
			ST_DRUN:   cmd.div_step  = 1'b1;
			ST_SLOAD:  cmd.sqrt_load = 1'b1;
			ST_SRUN:   cmd.sqrt_step = 1'b1;
			ST_RESULT: cmd.out_load  = result_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_ACC;
			op_q           <= pc_pkg::MUL_NSXX;
			cnt_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end

			case (state_q)
				ST_ACC: begin
					if (stat.last_pending) begin
						op_q    <= pc_pkg::MUL_NSXX;
						state_q <= ST_MLOAD;
					end
				end
				ST_MLOAD: begin
					cnt_q   <= '0;
					state_q <= ST_MRUN;
				end
				ST_MRUN: begin
					cnt_q <= cnt_q + CYC_W'(1);
					if (cnt_q == CYC_W'(pc_pkg::OP_W - 1)) begin
						state_q <= ST_MDONE;
					end
				end
				ST_MDONE: begin
					if (op_q == pc_pkg::MUL_NUMSQ) begin
						state_q <= ST_CHECK;
					end else begin
						op_q    <= pc_pkg::pc_mul_op_t'(op_q + 3'd1);
						state_q <= ST_MLOAD;
					end
				end
				ST_CHECK: begin
					cnt_q   <= '0;
					state_q <= stat.degenerate ? ST_RESULT : ST_DRUN;
				end
				ST_DRUN: begin
					cnt_q <= cnt_q + CYC_W'(1);
					if (cnt_q == CYC_W'(pc_pkg::Q_W - 1)) begin
						state_q <= ST_SLOAD;
					end
				end
				ST_SLOAD: begin
					cnt_q   <= '0;
					state_q <= ST_SRUN;
				end
				ST_SRUN: begin
					cnt_q <= cnt_q + CYC_W'(1);
					if (cnt_q == CYC_W'(pc_pkg::ROOT_W - 1)) begin
						state_q <= ST_RESULT;
					end
				end
				ST_RESULT: begin
					// hold until the output register is free
					if (result_free) begin
						state_q <= ST_ACC;
					end
				end
				default: state_q <= ST_ACC;
			endcase
		end
	end

	`PC_ASSERT_NXT(a_load_shows, cmd.out_load, result_valid_q && state_q == ST_ACC)
	`PC_ASSERT_IMP(a_one_unit, 1'b1,
		$onehot0({cmd.take, cmd.mul_step, cmd.div_step, cmd.sqrt_step}))
	`PC_ASSERT_NXT(a_result_hold, result_valid_q && !result_ready, result_valid_q)

endmodule

`default_nettype wire
